FILE: design/track_impact_parameter_top_macros.svh
// assertion macros for the track impact parameter block
// used by track_impact_parameter_top; expects clk and arst_n in scope
`ifndef TRACK_IMPACT_PARAMETER_TOP_MACROS_SVH
`define TRACK_IMPACT_PARAMETER_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define TIP_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("tip assertion failed");
`define TIP_ASSERT_ALWAYS(lbl, prop) \
	lbl: assert property (@(posedge clk) prop) \
		else $error("tip assertion failed");
`else
`define TIP_ASSERT(lbl, prop)
`define TIP_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

FILE: design/tip_pkg.sv
// package for the track impact parameter block
// widths, derived widths and the side-band tag; no dependencies
package tip_pkg;
	localparam int COORD_BITS = 20;
	localparam int MOM_BITS   = 20;
	localparam int DIST_BITS  = 22;

	localparam int D_W    = COORD_BITS + 1;
	localparam int PROD_W = MOM_BITS + D_W;
	localparam int CR_W   = PROD_W + 1;
	localparam int MAG_W  = CR_W;
	localparam int H_W    = MAG_W / 2;
	localparam int L_W    = MAG_W - H_W;
	localparam int SQ_W   = 2 * MAG_W;
	localparam int CSQ_W  = SQ_W + 2;
	localparam int PSQ_W  = 2 * MOM_BITS + 2;
	localparam int Q_W    = 2 * DIST_BITS;
	localparam int DIV_W  = (CSQ_W > PSQ_W + Q_W) ? CSQ_W : PSQ_W + Q_W;
	localparam int RT_W   = Q_W + 1;

	typedef struct packed {
		logic valid;
		logic no_dir;
		logic ovf;
	} tip_tag_t;
endpackage

FILE: design/tip_in_if.sv
// input channel of the track impact parameter block
// depends on tip_pkg
interface tip_in_if import tip_pkg::*; ();
	logic valid;
	logic ready;
	logic mode;
	logic signed [MOM_BITS-1:0] mom_x;
	logic signed [MOM_BITS-1:0] mom_y;
	logic signed [MOM_BITS-1:0] mom_z;
	logic signed [COORD_BITS-1:0] origin_x;
	logic signed [COORD_BITS-1:0] origin_y;
	logic signed [COORD_BITS-1:0] origin_z;
	logic signed [COORD_BITS-1:0] vertex_x;
	logic signed [COORD_BITS-1:0] vertex_y;
	logic signed [COORD_BITS-1:0] vertex_z;

	modport source (output valid, mode, mom_x, mom_y, mom_z, origin_x, origin_y, origin_z,
		vertex_x, vertex_y, vertex_z, input ready);
	modport sink (input valid, mode, mom_x, mom_y, mom_z, origin_x, origin_y, origin_z,
		vertex_x, vertex_y, vertex_z, output ready);
endinterface

FILE: design/tip_out_if.sv
// output channel of the track impact parameter block
// depends on tip_pkg
interface tip_out_if import tip_pkg::*; ();
	logic valid;
	logic ready;
	logic [DIST_BITS-1:0] distance;
	logic no_direction;

	modport source (output valid, distance, no_direction, input ready);
	modport sink (input valid, distance, no_direction, output ready);
endinterface

FILE: design/track_impact_parameter_top.sv
// throughput: one beat per cycle; the whole pipe holds while a result waits
// cross products and squares take eight stages, the divider one stage per
// quotient bit, the square root one stage per root bit, then the output register
// asynchronous active-low reset clears the valid bits and the side-band tags only
module track_impact_parameter_top import tip_pkg::*; (
	input logic clk,
	input logic arst_n,
	tip_in_if.sink in,
	tip_out_if.source out
);
`include "track_impact_parameter_top_macros.svh"

	logic en;
	assign en       = !out.valid || out.ready;
	assign in.ready = en;

	// s1: displacement
	logic v_s1, mode_s1;
	logic signed [MOM_BITS-1:0] px_s1, py_s1, pz_s1;
	logic signed [D_W-1:0] dx_s1, dy_s1, dz_s1;
	// s2: products and momentum squares
	logic v_s2, mode_s2;
	logic signed [PROD_W-1:0] pxdy_s2, pydx_s2, pydz_s2, pzdy_s2, pzdx_s2, pxdz_s2;
	logic [2*MOM_BITS-1:0] pxx_s2, pyy_s2, pzz_s2;
	// s3: cross components
	logic v_s3, mode_s3;
	logic signed [CR_W-1:0] cx_s3, cy_s3, cz_s3;
	logic [PSQ_W-1:0] psq_s3;
	// s4: magnitudes
	logic v_s4;
	logic [MAG_W-1:0] ax_s4, ay_s4, az_s4;
	logic [PSQ_W-1:0] psq_s4;
	// s5: partial products of the squares
	logic v_s5;
	logic [2*L_W-1:0] hhx_s5, hhy_s5, hhz_s5;
	logic [L_W+H_W-1:0] hlx_s5, hly_s5, hlz_s5;
	logic [2*H_W-1:0] llx_s5, lly_s5, llz_s5;
	logic [PSQ_W-1:0] psq_s5;
	// s6: squares
	logic v_s6;
	logic [SQ_W-1:0] sqx_s6, sqy_s6, sqz_s6;
	logic [PSQ_W-1:0] psq_s6;
	// s7: sum of squares
	logic v_s7;
	logic [CSQ_W-1:0] csq_s7;
	logic [PSQ_W-1:0] psq_s7;
	// s8: flags
	tip_tag_t tag_s8;
	logic [CSQ_W-1:0] csq_s8;
	logic [PSQ_W-1:0] psq_s8;

	function automatic logic [MOM_BITS-1:0] mag_p(input logic signed [MOM_BITS-1:0] v);
		mag_p = v[MOM_BITS-1] ? MOM_BITS'(-v) : MOM_BITS'(v);
	endfunction

	function automatic logic [MAG_W-1:0] mag_c(input logic signed [CR_W-1:0] v);
		mag_c = v[CR_W-1] ? MAG_W'(-v) : MAG_W'(v);
	endfunction

	function automatic logic [SQ_W-1:0] join_sq(input logic [2*L_W-1:0] hh,
		input logic [L_W+H_W-1:0] hl, input logic [2*H_W-1:0] ll);
		join_sq = (SQ_W'(hh) << (2 * H_W)) + (SQ_W'(hl) << (H_W + 1)) + SQ_W'(ll);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			v_s3   <= 1'b0;
			v_s4   <= 1'b0;
			v_s5   <= 1'b0;
			v_s6   <= 1'b0;
			v_s7   <= 1'b0;
			tag_s8 <= '0;
		end else if (en) begin
			v_s1          <= in.valid;
			v_s2          <= v_s1;
			v_s3          <= v_s2;
			v_s4          <= v_s3;
			v_s5          <= v_s4;
			v_s6          <= v_s5;
			v_s7          <= v_s6;
			tag_s8.valid  <= v_s7;
			tag_s8.no_dir <= psq_s7 == '0;
			tag_s8.ovf    <= DIV_W'(csq_s7) >= (DIV_W'(psq_s7) << Q_W);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mode_s1 <= in.mode;
			px_s1   <= in.mom_x;
			py_s1   <= in.mom_y;
			pz_s1   <= in.mom_z;
			dx_s1   <= D_W'(in.vertex_x) - D_W'(in.origin_x);
			dy_s1   <= D_W'(in.vertex_y) - D_W'(in.origin_y);
			dz_s1   <= D_W'(in.vertex_z) - D_W'(in.origin_z);

			mode_s2 <= mode_s1;
			pxdy_s2 <= PROD_W'(px_s1) * PROD_W'(dy_s1);
			pydx_s2 <= PROD_W'(py_s1) * PROD_W'(dx_s1);
			pydz_s2 <= PROD_W'(py_s1) * PROD_W'(dz_s1);
			pzdy_s2 <= PROD_W'(pz_s1) * PROD_W'(dy_s1);
			pzdx_s2 <= PROD_W'(pz_s1) * PROD_W'(dx_s1);
			pxdz_s2 <= PROD_W'(px_s1) * PROD_W'(dz_s1);
			pxx_s2  <= (2*MOM_BITS)'(mag_p(px_s1)) * (2*MOM_BITS)'(mag_p(px_s1));
			pyy_s2  <= (2*MOM_BITS)'(mag_p(py_s1)) * (2*MOM_BITS)'(mag_p(py_s1));
			pzz_s2  <= (2*MOM_BITS)'(mag_p(pz_s1)) * (2*MOM_BITS)'(mag_p(pz_s1));

			// transverse mode keeps only the z cross component and px, py
			mode_s3 <= mode_s2;
			cz_s3   <= CR_W'(pxdy_s2) - CR_W'(pydx_s2);
			cx_s3   <= mode_s2 ? '0 : CR_W'(pydz_s2) - CR_W'(pzdy_s2);
			cy_s3   <= mode_s2 ? '0 : CR_W'(pzdx_s2) - CR_W'(pxdz_s2);
			psq_s3  <= PSQ_W'(pxx_s2) + PSQ_W'(pyy_s2) + (mode_s2 ? '0 : PSQ_W'(pzz_s2));

			ax_s4  <= mag_c(cx_s3);
			ay_s4  <= mag_c(cy_s3);
			az_s4  <= mag_c(cz_s3);
			psq_s4 <= psq_s3;

			hhx_s5 <= (2*L_W)'(ax_s4[MAG_W-1:H_W]) * (2*L_W)'(ax_s4[MAG_W-1:H_W]);
			hhy_s5 <= (2*L_W)'(ay_s4[MAG_W-1:H_W]) * (2*L_W)'(ay_s4[MAG_W-1:H_W]);
			hhz_s5 <= (2*L_W)'(az_s4[MAG_W-1:H_W]) * (2*L_W)'(az_s4[MAG_W-1:H_W]);
			hlx_s5 <= (L_W+H_W)'(ax_s4[MAG_W-1:H_W]) * (L_W+H_W)'(ax_s4[H_W-1:0]);
			hly_s5 <= (L_W+H_W)'(ay_s4[MAG_W-1:H_W]) * (L_W+H_W)'(ay_s4[H_W-1:0]);
			hlz_s5 <= (L_W+H_W)'(az_s4[MAG_W-1:H_W]) * (L_W+H_W)'(az_s4[H_W-1:0]);
			llx_s5 <= (2*H_W)'(ax_s4[H_W-1:0]) * (2*H_W)'(ax_s4[H_W-1:0]);
			lly_s5 <= (2*H_W)'(ay_s4[H_W-1:0]) * (2*H_W)'(ay_s4[H_W-1:0]);
			llz_s5 <= (2*H_W)'(az_s4[H_W-1:0]) * (2*H_W)'(az_s4[H_W-1:0]);
			psq_s5 <= psq_s4;

			sqx_s6 <= join_sq(hhx_s5, hlx_s5, llx_s5);
			sqy_s6 <= join_sq(hhy_s5, hly_s5, lly_s5);
			sqz_s6 <= join_sq(hhz_s5, hlz_s5, llz_s5);
			psq_s6 <= psq_s5;

			csq_s7 <= CSQ_W'(sqx_s6) + CSQ_W'(sqy_s6) + CSQ_W'(sqz_s6);
			psq_s7 <= psq_s6;

			csq_s8 <= csq_s7;
			psq_s8 <= psq_s7;
		end
	end

	tip_tag_t div_tag;
	logic [Q_W-1:0] quo;

	tip_divider u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.tag_i  (tag_s8),
		.num    (csq_s8),
		.den    (psq_s8),
		.tag_o  (div_tag),
		.quo    (quo)
	);

	tip_tag_t rt_tag;
	logic [DIST_BITS-1:0] root;

	tip_isqrt u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.tag_i  (div_tag),
		.rad    (quo),
		.tag_o  (rt_tag),
		.root   (root)
	);

	logic valid_q;
	logic ovf_q;
	logic [DIST_BITS-1:0] dist_q;
	logic no_dir_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= rt_tag.valid;
		end
	end

	// no direction gives zero; a quotient too large for the quotient field saturates
	always_ff @(posedge clk) begin
		if (en) begin
			no_dir_q <= rt_tag.no_dir;
			ovf_q    <= rt_tag.ovf;
			if (rt_tag.no_dir) begin
				dist_q <= '0;
			end else if (rt_tag.ovf) begin
				dist_q <= '1;
			end else begin
				dist_q <= root;
			end
		end
	end

	assign out.valid        = valid_q;
	assign out.distance     = dist_q;
	assign out.no_direction = no_dir_q;

	`TIP_ASSERT(a_nodir_zero, out.valid && out.no_direction |-> out.distance == '0)
	`TIP_ASSERT(a_ovf_sat, out.valid && ovf_q && !out.no_direction |-> out.distance == '1)
	`TIP_ASSERT(a_trans_mask, v_s3 && mode_s3 |-> cx_s3 == '0 && cy_s3 == '0)
	`TIP_ASSERT_ALWAYS(a_rst_empty, !arst_n |=> !out.valid)
endmodule

FILE: design/tip_divider.sv
// pipelined restoring divider, one quotient bit per stage
// depends on tip_pkg; tag rides along with the data
module tip_divider import tip_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  tip_tag_t         tag_i,
	input  logic [CSQ_W-1:0] num,
	input  logic [PSQ_W-1:0] den,
	output tip_tag_t         tag_o,
	output logic [Q_W-1:0]   quo
);
	logic [DIV_W-1:0] rem_s [1:Q_W];
	logic [Q_W-1:0]   quo_s [1:Q_W];
	logic [PSQ_W-1:0] den_s [1:Q_W];
	tip_tag_t         tag_s [1:Q_W];

	genvar k;
	for (k = 0; k < Q_W; k++) begin : g_step
		logic [DIV_W-1:0] rem_in;
		logic [Q_W-1:0]   quo_in;
		logic [PSQ_W-1:0] den_in;
		tip_tag_t         tag_in;
		logic [DIV_W-1:0] trial;
		logic             ge;

		if (k == 0) begin : g_first
			assign rem_in = DIV_W'(num);
			assign quo_in = '0;
			assign den_in = den;
			assign tag_in = tag_i;
		end else begin : g_next
			assign rem_in = rem_s[k];
			assign quo_in = quo_s[k];
			assign den_in = den_s[k];
			assign tag_in = tag_s[k];
		end

		// quotient bit Q_W-1-k
		assign trial = DIV_W'(den_in) << (Q_W - 1 - k);
		assign ge    = rem_in >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				tag_s[k+1] <= '0;
			end else if (en) begin
				tag_s[k+1] <= tag_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1] <= ge ? rem_in - trial : rem_in;
				quo_s[k+1] <= quo_in | (Q_W'(ge) << (Q_W - 1 - k));
				den_s[k+1] <= den_in;
			end
		end
	end

	assign tag_o = tag_s[Q_W];
	assign quo   = quo_s[Q_W];
endmodule

FILE: design/tip_isqrt.sv
// pipelined integer square root, one root bit per stage
// depends on tip_pkg; tag rides along with the data
module tip_isqrt import tip_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  tip_tag_t             tag_i,
	input  logic [Q_W-1:0]       rad,
	output tip_tag_t             tag_o,
	output logic [DIST_BITS-1:0] root
);
	logic [RT_W-1:0] op_s  [1:DIST_BITS];
	logic [RT_W-1:0] res_s [1:DIST_BITS];
	tip_tag_t        tag_s [1:DIST_BITS];

	genvar k;
	for (k = 0; k < DIST_BITS; k++) begin : g_step
		logic [RT_W-1:0] op_in;
		logic [RT_W-1:0] res_in;
		tip_tag_t        tag_in;
		logic [RT_W-1:0] one;
		logic [RT_W-1:0] trial;
		logic            ge;

		if (k == 0) begin : g_first
			assign op_in  = RT_W'(rad);
			assign res_in = '0;
			assign tag_in = tag_i;
		end else begin : g_next
			assign op_in  = op_s[k];
			assign res_in = res_s[k];
			assign tag_in = tag_s[k];
		end

		assign one   = RT_W'(1) << (Q_W - 2 - 2 * k);
		assign trial = res_in + one;
		assign ge    = op_in >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				tag_s[k+1] <= '0;
			end else if (en) begin
				tag_s[k+1] <= tag_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				op_s[k+1]  <= ge ? op_in - trial : op_in;
				res_s[k+1] <= ge ? (res_in >> 1) + one : res_in >> 1;
			end
		end
	end

	assign tag_o = tag_s[DIST_BITS];
	assign root  = res_s[DIST_BITS][DIST_BITS-1:0];
endmodule
